>>> rtl/gradient_noise_3d_unit_defines.svh
// ----------------------------------------------------------------------------
// gradient_noise_3d_unit_defines.svh
// Assertion macros for the gradient noise unit. Empty when SYNTH is set.
// ----------------------------------------------------------------------------
`ifndef GRADIENT_NOISE_3D_UNIT_DEFINES_SVH
`define GRADIENT_NOISE_3D_UNIT_DEFINES_SVH

`ifndef SYNTH
// same-cycle implication
`define GN3D_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("gn3d assertion failed");
// next-cycle implication
`define GN3D_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("gn3d assertion failed");
`else
`define GN3D_ASSERT_IMPL(lbl, clk, rst_n, ante, cons)
`define GN3D_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif

`endif

>>> rtl/gn3d_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gn3d_pkg
// Shared widths, types and opcodes of the 3D gradient noise unit.
// ----------------------------------------------------------------------------
package gn3d_pkg;

	localparam int FRAC_BITS  = 16;
	localparam int IDX_W      = 8;
	localparam int TABLE_SIZE = 1 << IDX_W;
	localparam int COORD_W    = 24;
	localparam int ONE        = 1 << FRAC_BITS;
	localparam int FADE_W     = FRAC_BITS + 1;
	localparam int Q_W        = FRAC_BITS + 4;
	localparam int GRAD_W     = FRAC_BITS + 3;
	localparam int LERP_W     = FRAC_BITS + 4;
	localparam int PROD_W     = FADE_W + 1 + LERP_W;
	localparam int HGT_W      = 5;

	typedef logic [IDX_W-1:0]          idx_t;
	typedef logic [FRAC_BITS-1:0]      frac_t;
	typedef logic [FADE_W-1:0]         fade_t;
	typedef logic signed [GRAD_W-1:0]  grad_t;
	typedef logic signed [LERP_W-1:0]  lerp_t;
	typedef logic signed [PROD_W-1:0]  prod_t;

	localparam logic OP_LOAD = 1'b0;
	localparam logic OP_EVAL = 1'b1;

endpackage

>>> rtl/gn3d_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gn3d_ram
// Generic RAM: one write port, two read ports with registered read data.
// ----------------------------------------------------------------------------
module gn3d_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr_a,
	input  logic [$clog2(DEPTH)-1:0] raddr_b,
	output logic [WIDTH-1:0]         rdata_a,
	output logic [WIDTH-1:0]         rdata_b
);

	logic [WIDTH-1:0] mem [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// registered reads
	always_ff @(posedge clk) begin
		rdata_a <= mem[raddr_a];
		rdata_b <= mem[raddr_b];
	end

endmodule

>>> rtl/gn3d_fade.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gn3d_fade
// Three-stage fade curve 6t^5-15t^4+10t^3 in fixed point, one value per cycle.
// ----------------------------------------------------------------------------
module gn3d_fade import gn3d_pkg::*; (
	input  logic  clk,
	input  frac_t t,
	output fade_t fade_s4
);

	logic [2*FRAC_BITS-1:0]      sq;
	logic [2*FRAC_BITS-1:0]      cube;
	logic [Q_W:0]                q_sum;
	logic [FRAC_BITS+Q_W-1:0]    prod;
	frac_t                       t_s2;
	frac_t                       t2_s2;
	frac_t                       t3_s3;
	logic [Q_W-1:0]              q_s3;

	// t^2, t^3 and the quadratic factor
	always_comb begin
		sq    = t * t;
		cube  = t2_s2 * t_s2;
		q_sum = (Q_W+1)'(t2_s2) * (Q_W+1)'(6) + (Q_W+1)'(10 * ONE)
			- (Q_W+1)'(t_s2) * (Q_W+1)'(15);
		prod  = t3_s3 * q_s3;
	end

	always_ff @(posedge clk) begin
		t_s2    <= t;
		t2_s2   <= sq[FRAC_BITS +: FRAC_BITS];
		t3_s3   <= cube[FRAC_BITS +: FRAC_BITS];
		q_s3    <= q_sum[Q_W-1:0];
		fade_s4 <= prod[FRAC_BITS +: FADE_W];
	end

endmodule

>>> rtl/gradient_noise_3d_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gradient_noise_3d_unit
// Improved 3D gradient noise in fixed point with a loadable permutation table.
// ----------------------------------------------------------------------------
//  channel   handshake          payload
//  request   start / busy       op, perm_index, perm_value, coord_x/y/z
//  result    done (strobe)      noise_value, height
//
// One request is taken every cycle; busy stays low. An evaluate request
// gives its result at the end of the ten-stage pipeline (table lookups, fade
// multiplies, three lerp levels, height scaling).
// Load requests travel the same pipeline and write each table copy at the
// stage that reads it, so order against evaluations holds. No result for a
// load. Reset clears the valid bits only; the table is undefined until loaded.
// ----------------------------------------------------------------------------
`include "gradient_noise_3d_unit_defines.svh"

module gradient_noise_3d_unit import gn3d_pkg::*; (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      start,
	output logic                      busy,
	input  logic                      op,
	input  logic [IDX_W-1:0]          perm_index,
	input  logic [IDX_W-1:0]          perm_value,
	input  logic [COORD_W-1:0]        coord_x,
	input  logic [COORD_W-1:0]        coord_y,
	input  logic [COORD_W-1:0]        coord_z,
	output logic                      done,
	output logic signed [GRAD_W-1:0]  noise_value,
	output logic signed [HGT_W-1:0]   height
);

	localparam int HW = LERP_W + 3;

	function automatic grad_t grad(input idx_t h,
		input logic signed [FRAC_BITS+1:0] gx, gy, gz);
		grad_t ex;
		grad_t ey;
		grad_t ez;
		ex = h[0] ? GRAD_W'(gx) : -GRAD_W'(gx);
		ey = h[1] ? GRAD_W'(gy) : -GRAD_W'(gy);
		ez = h[2] ? GRAD_W'(gz) : -GRAD_W'(gz);
		return ex + ey + ez;
	endfunction

	logic accept;
	logic ev_s1, ev_s2, ev_s3, ev_s4, ev_s5, ev_s6, ev_s7, ev_s8, ev_s9, ev_s10;
	logic ld_s1, ld_s2, ld_s3;
	idx_t idx_s1, idx_s2, idx_s3, val_s1, val_s2, val_s3;
	idx_t xc_s1, yc_s1, yc_s2, zc_s1, zc_s2, zc_s3;
	frac_t fx_s1, fx_s2, fx_s3, fx_s4;
	frac_t fy_s1, fy_s2, fy_s3, fy_s4;
	frac_t fz_s1, fz_s2, fz_s3, fz_s4;
	fade_t u_s4, v_s4, w_s4, u_s5, v_s5, v_s6, w_s5, w_s6, w_s7;
	idx_t px_s2, px1_s2, pa_s3, pa1_s3, pb_s3, pb1_s3;
	idx_t a_hash, b_hash, aa_hash, ab_hash, ba_hash, bb_hash;
	idx_t h_s4 [8];
	grad_t g_s5 [8];
	prod_t prod_u_s6 [4];
	lerp_t ga_s6 [4];
	lerp_t l_lerp [4];
	prod_t prod_v_s7 [2];
	lerp_t la_s7 [2];
	lerp_t m_lerp [2];
	prod_t prod_w_s8;
	lerp_t ma_s8;
	lerp_t r_s9;
	logic signed [FRAC_BITS+1:0] x0, y0, z0, x1, y1, z1;
	logic signed [HW-1:0] num;
	logic signed [HW-1:0] hgt;
	grad_t noise_s10;
	logic signed [HGT_W-1:0] height_s10;

	assign accept = start && !busy;
	assign busy   = 1'b0;

	// valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ev_s1 <= 1'b0; ev_s2 <= 1'b0; ev_s3 <= 1'b0; ev_s4 <= 1'b0;
			ev_s5 <= 1'b0; ev_s6 <= 1'b0; ev_s7 <= 1'b0; ev_s8 <= 1'b0;
			ev_s9 <= 1'b0; ev_s10 <= 1'b0;
			ld_s1 <= 1'b0; ld_s2 <= 1'b0; ld_s3 <= 1'b0;
		end else begin
			ev_s1 <= accept && (op == OP_EVAL);
			ld_s1 <= accept && (op == OP_LOAD);
			ev_s2 <= ev_s1; ev_s3 <= ev_s2; ev_s4 <= ev_s3; ev_s5 <= ev_s4;
			ev_s6 <= ev_s5; ev_s7 <= ev_s6; ev_s8 <= ev_s7; ev_s9 <= ev_s8;
			ev_s10 <= ev_s9;
			ld_s2 <= ld_s1; ld_s3 <= ld_s2;
		end
	end

	// request capture and payload carry
	always_ff @(posedge clk) begin
		idx_s1 <= perm_index; val_s1 <= perm_value;
		xc_s1  <= coord_x[FRAC_BITS +: IDX_W];
		yc_s1  <= coord_y[FRAC_BITS +: IDX_W];
		zc_s1  <= coord_z[FRAC_BITS +: IDX_W];
		fx_s1  <= coord_x[FRAC_BITS-1:0];
		fy_s1  <= coord_y[FRAC_BITS-1:0];
		fz_s1  <= coord_z[FRAC_BITS-1:0];
		idx_s2 <= idx_s1; val_s2 <= val_s1; idx_s3 <= idx_s2; val_s3 <= val_s2;
		yc_s2  <= yc_s1; zc_s2 <= zc_s1; zc_s3 <= zc_s2;
		fx_s2  <= fx_s1; fx_s3 <= fx_s2; fx_s4 <= fx_s3;
		fy_s2  <= fy_s1; fy_s3 <= fy_s2; fy_s4 <= fy_s3;
		fz_s2  <= fz_s1; fz_s3 <= fz_s2; fz_s4 <= fz_s3;
		u_s5   <= u_s4; v_s5 <= v_s4; v_s6 <= v_s5;
		w_s5   <= w_s4; w_s6 <= w_s5; w_s7 <= w_s6;
	end

	// fade curves
	gn3d_fade u_fade_x (.clk(clk), .t(fx_s1), .fade_s4(u_s4));
	gn3d_fade u_fade_y (.clk(clk), .t(fy_s1), .fade_s4(v_s4));
	gn3d_fade u_fade_z (.clk(clk), .t(fz_s1), .fade_s4(w_s4));

	// hash level 1: perm[X], perm[X+1]
	gn3d_ram #(.WIDTH(IDX_W), .DEPTH(TABLE_SIZE)) u_ram_l1 (
		.clk(clk), .we(ld_s1), .waddr(idx_s1), .wdata(val_s1),
		.raddr_a(xc_s1), .raddr_b(xc_s1 + idx_t'(1)),
		.rdata_a(px_s2), .rdata_b(px1_s2));

	// hash level 2: A, A+1, B, B+1
	assign a_hash = px_s2 + yc_s2;
	assign b_hash = px1_s2 + yc_s2;

	gn3d_ram #(.WIDTH(IDX_W), .DEPTH(TABLE_SIZE)) u_ram_l2a (
		.clk(clk), .we(ld_s2), .waddr(idx_s2), .wdata(val_s2),
		.raddr_a(a_hash), .raddr_b(a_hash + idx_t'(1)),
		.rdata_a(pa_s3), .rdata_b(pa1_s3));

	gn3d_ram #(.WIDTH(IDX_W), .DEPTH(TABLE_SIZE)) u_ram_l2b (
		.clk(clk), .we(ld_s2), .waddr(idx_s2), .wdata(val_s2),
		.raddr_a(b_hash), .raddr_b(b_hash + idx_t'(1)),
		.rdata_a(pb_s3), .rdata_b(pb1_s3));

	// hash level 3: corner hashes
	assign aa_hash = pa_s3 + zc_s3;
	assign ab_hash = pa1_s3 + zc_s3;
	assign ba_hash = pb_s3 + zc_s3;
	assign bb_hash = pb1_s3 + zc_s3;

	gn3d_ram #(.WIDTH(IDX_W), .DEPTH(TABLE_SIZE)) u_ram_aa (
		.clk(clk), .we(ld_s3), .waddr(idx_s3), .wdata(val_s3),
		.raddr_a(aa_hash), .raddr_b(aa_hash + idx_t'(1)),
		.rdata_a(h_s4[0]), .rdata_b(h_s4[4]));

	gn3d_ram #(.WIDTH(IDX_W), .DEPTH(TABLE_SIZE)) u_ram_ba (
		.clk(clk), .we(ld_s3), .waddr(idx_s3), .wdata(val_s3),
		.raddr_a(ba_hash), .raddr_b(ba_hash + idx_t'(1)),
		.rdata_a(h_s4[1]), .rdata_b(h_s4[5]));

	gn3d_ram #(.WIDTH(IDX_W), .DEPTH(TABLE_SIZE)) u_ram_ab (
		.clk(clk), .we(ld_s3), .waddr(idx_s3), .wdata(val_s3),
		.raddr_a(ab_hash), .raddr_b(ab_hash + idx_t'(1)),
		.rdata_a(h_s4[2]), .rdata_b(h_s4[6]));

	gn3d_ram #(.WIDTH(IDX_W), .DEPTH(TABLE_SIZE)) u_ram_bb (
		.clk(clk), .we(ld_s3), .waddr(idx_s3), .wdata(val_s3),
		.raddr_a(bb_hash), .raddr_b(bb_hash + idx_t'(1)),
		.rdata_a(h_s4[3]), .rdata_b(h_s4[7]));

	// corner gradients
	always_comb begin
		x0 = $signed({2'b00, fx_s4});
		y0 = $signed({2'b00, fy_s4});
		z0 = $signed({2'b00, fz_s4});
		x1 = x0 - (FRAC_BITS+2)'(ONE);
		y1 = y0 - (FRAC_BITS+2)'(ONE);
		z1 = z0 - (FRAC_BITS+2)'(ONE);
	end

	always_ff @(posedge clk) begin
		g_s5[0] <= grad(h_s4[0], x0, y0, z0);
		g_s5[1] <= grad(h_s4[1], x1, y0, z0);
		g_s5[2] <= grad(h_s4[2], x0, y1, z0);
		g_s5[3] <= grad(h_s4[3], x1, y1, z0);
		g_s5[4] <= grad(h_s4[4], x0, y0, z1);
		g_s5[5] <= grad(h_s4[5], x1, y0, z1);
		g_s5[6] <= grad(h_s4[6], x0, y1, z1);
		g_s5[7] <= grad(h_s4[7], x1, y1, z1);
	end

	// lerp along x: multiply stage
	always_ff @(posedge clk) begin
		for (int i = 0; i < 4; i++) begin
			prod_u_s6[i] <= $signed({1'b0, u_s5})
				* (LERP_W'(g_s5[2*i+1]) - LERP_W'(g_s5[2*i]));
			ga_s6[i] <= LERP_W'(g_s5[2*i]);
		end
	end

	// finish x lerp, multiply for y
	always_comb begin
		for (int i = 0; i < 4; i++) begin
			l_lerp[i] = ga_s6[i] + LERP_W'(prod_u_s6[i] >>> FRAC_BITS);
		end
	end

	always_ff @(posedge clk) begin
		for (int j = 0; j < 2; j++) begin
			prod_v_s7[j] <= $signed({1'b0, v_s6}) * (l_lerp[2*j+1] - l_lerp[2*j]);
			la_s7[j]     <= l_lerp[2*j];
		end
	end

	// finish y lerp, multiply for z
	always_comb begin
		for (int j = 0; j < 2; j++) begin
			m_lerp[j] = la_s7[j] + LERP_W'(prod_v_s7[j] >>> FRAC_BITS);
		end
	end

	always_ff @(posedge clk) begin
		prod_w_s8 <= $signed({1'b0, w_s7}) * (m_lerp[1] - m_lerp[0]);
		ma_s8     <= m_lerp[0];
		r_s9      <= ma_s8 + LERP_W'(prod_w_s8 >>> FRAC_BITS);
	end

	// height = (noise + 1) * 5, truncated toward zero
	always_comb begin
		num = (HW'(r_s9) + HW'(ONE)) * HW'(5);
		if (num < 0) begin
			hgt = -((-num) >>> FRAC_BITS);
		end else begin
			hgt = num >>> FRAC_BITS;
		end
	end

	always_ff @(posedge clk) begin
		noise_s10  <= r_s9[GRAD_W-1:0];
		height_s10 <= hgt[HGT_W-1:0];
	end

	assign done        = ev_s10;
	assign noise_value = noise_s10;
	assign height      = height_s10;

	// checks
	`GN3D_ASSERT_IMPL(a_done_latency, clk, arst_n, done, $past(start && !busy && (op == OP_EVAL), 10))
	`GN3D_ASSERT_IMPL(a_fade_range, clk, arst_n, ev_s5, (u_s5 <= FADE_W'(ONE)) && (v_s5 <= FADE_W'(ONE)) && (w_s5 <= FADE_W'(ONE)))
	`GN3D_ASSERT_IMPL(a_noise_range, clk, arst_n, done, (noise_value >= -19'sd196608) && (noise_value <= 19'sd196608))
	`GN3D_ASSERT_NEXT(a_load_no_result, clk, arst_n, ld_s3, !ev_s4)

endmodule

>>> verif/gradient_noise_3d_unit_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gradient_noise_3d_unit_checker
// Watches the request and result channels of the noise unit, keeps its own
// copy of the permutation table, predicts each noise sample and compares it
// field by field against the strobed results in order.
// ----------------------------------------------------------------------------
module gradient_noise_3d_unit_checker import gn3d_pkg::*; (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      start,
	input  logic                      busy,
	input  logic                      op,
	input  logic [IDX_W-1:0]          perm_index,
	input  logic [IDX_W-1:0]          perm_value,
	input  logic [COORD_W-1:0]        coord_x,
	input  logic [COORD_W-1:0]        coord_y,
	input  logic [COORD_W-1:0]        coord_z,
	input  logic                      done,
	input  logic signed [GRAD_W-1:0]  noise_value,
	input  logic signed [HGT_W-1:0]   height,
	output int                        errors,
	output int                        samples_pending,
	output int                        samples_checked
);

	typedef struct {
		logic signed [GRAD_W-1:0] noise;
		logic signed [HGT_W-1:0]  hgt;
	} sample_t;

	sample_t    samples_due[$];
	logic [7:0] perm_copy [TABLE_SIZE];

	function automatic longint fade_of(longint t);
		longint t2, t3, q;
		t2 = (t * t) >> FRAC_BITS;
		t3 = (t2 * t) >> FRAC_BITS;
		q  = 6 * t2 + 10 * longint'(ONE) - 15 * t;
		return (t3 * q) >> FRAC_BITS;
	endfunction

	// arithmetic shift gives the floor toward minus infinity
	function automatic longint mix(longint t, longint a, longint b);
		return a + ((t * (b - a)) >>> FRAC_BITS);
	endfunction

	function automatic longint grad_dot(int h, longint x, longint y, longint z);
		return (h[0] ? x : -x) + (h[1] ? y : -y) + (h[2] ? z : -z);
	endfunction

	function automatic int perm_rd(int i);
		return int'(perm_copy[i & (TABLE_SIZE - 1)]);
	endfunction

	function automatic sample_t noise_at(logic [COORD_W-1:0] cx, logic [COORD_W-1:0] cy,
			logic [COORD_W-1:0] cz);
		int      xi, yi, zi, a, aa, ab, b, ba, bb;
		longint  x, y, z, x1, y1, z1, u, v, w, r, h;
		sample_t s;
		xi = int'(cx[COORD_W-1:FRAC_BITS]);
		yi = int'(cy[COORD_W-1:FRAC_BITS]);
		zi = int'(cz[COORD_W-1:FRAC_BITS]);
		x  = longint'(cx[FRAC_BITS-1:0]);
		y  = longint'(cy[FRAC_BITS-1:0]);
		z  = longint'(cz[FRAC_BITS-1:0]);
		x1 = x - ONE;
		y1 = y - ONE;
		z1 = z - ONE;
		u  = fade_of(x);
		v  = fade_of(y);
		w  = fade_of(z);
		// corner hashes, all indexes wrap to the table size
		a  = (perm_rd(xi) + yi) & (TABLE_SIZE - 1);
		aa = (perm_rd(a) + zi) & (TABLE_SIZE - 1);
		ab = (perm_rd(a + 1) + zi) & (TABLE_SIZE - 1);
		b  = (perm_rd(xi + 1) + yi) & (TABLE_SIZE - 1);
		ba = (perm_rd(b) + zi) & (TABLE_SIZE - 1);
		bb = (perm_rd(b + 1) + zi) & (TABLE_SIZE - 1);
		r = mix(w,
			mix(v, mix(u, grad_dot(perm_rd(aa), x, y, z), grad_dot(perm_rd(ba), x1, y, z)),
				mix(u, grad_dot(perm_rd(ab), x, y1, z), grad_dot(perm_rd(bb), x1, y1, z))),
			mix(v, mix(u, grad_dot(perm_rd(aa + 1), x, y, z1),
					grad_dot(perm_rd(ba + 1), x1, y, z1)),
				mix(u, grad_dot(perm_rd(ab + 1), x, y1, z1),
					grad_dot(perm_rd(bb + 1), x1, y1, z1))));
		if (r > 262143) r = 262143;
		if (r < -262144) r = -262144;
		// integer division truncates toward zero
		h = ((r + ONE) * 5) / ONE;
		if (h > 15) h = 15;
		if (h < -16) h = -16;
		s.noise = r[GRAD_W-1:0];
		s.hgt   = h[HGT_W-1:0];
		return s;
	endfunction

	task automatic report_mismatch(string what, longint want, longint got);
		$display("[%0t] mismatch on %s: expected %0d, got %0d", $time, what, want, got);
		errors++;
	endtask

	initial begin
		errors          = 0;
		samples_pending = 0;
		samples_checked = 0;
	end

	// requests: loads update the table copy, evaluations queue a prediction
	always @(posedge clk) begin
		if (arst_n && start && !busy) begin
			if (op == OP_LOAD) begin
				perm_copy[perm_index] = perm_value;
			end else begin
				samples_due = {samples_due, noise_at(coord_x, coord_y, coord_z)};
			end
		end
		// results are compared against the oldest prediction
		if (arst_n && done) begin
			if (samples_due.size() == 0) begin
				report_mismatch("unexpected result, noise", 0, noise_value);
			end else begin
				sample_t s;
				s = samples_due.pop_front();
				if (noise_value !== s.noise) report_mismatch("noise_value", s.noise, noise_value);
				if (height !== s.hgt) report_mismatch("height", s.hgt, height);
			end
			samples_checked++;
		end
		samples_pending = samples_due.size();
	end

endmodule

>>> verif/gradient_noise_3d_unit_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gradient_noise_3d_unit_tb
// Loads a shuffled permutation table, sends directed corner points, then a
// random mix of noise samples and table rewrites with random request gaps.
// The checker predicts and compares; this top drives and gives the verdict.
// ----------------------------------------------------------------------------
module gradient_noise_3d_unit_tb;
	import gn3d_pkg::*;

	localparam int IDLE_LIMIT = 500;

	logic                     clk;
	logic                     arst_n;
	logic                     start;
	logic                     busy;
	logic                     op;
	logic [IDX_W-1:0]         perm_index;
	logic [IDX_W-1:0]         perm_value;
	logic [COORD_W-1:0]       coord_x;
	logic [COORD_W-1:0]       coord_y;
	logic [COORD_W-1:0]       coord_z;
	logic                     done;
	logic signed [GRAD_W-1:0] noise_value;
	logic signed [HGT_W-1:0]  height;
	int                       errors;
	int                       samples_pending;
	int                       samples_checked;
	int                       idle_cycles;
	int                       loads_sent;

	gradient_noise_3d_unit dut (.*);

	gradient_noise_3d_unit_checker chk (.*);

	// clock
	always begin
		clk = 1'b1; #5;
		clk = 1'b0; #5;
	end

	// watchdog: cycles with no request and no result taken
	always @(posedge clk) begin
		if ((start && !busy) || done) idle_cycles <= 0;
		else idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("watchdog expired after %0d idle cycles", IDLE_LIMIT);
			$display("FAILED: results differ");
			$finish;
		end
	end

	// drive one request at the falling edge and hold it until taken
	task automatic send_request(logic o, logic [7:0] pi, logic [7:0] pv,
			logic [23:0] cx, logic [23:0] cy, logic [23:0] cz);
		int gap;
		@(negedge clk);
		op = o; perm_index = pi; perm_value = pv;
		coord_x = cx; coord_y = cy; coord_z = cz;
		start = 1'b1;
		while (busy) @(negedge clk);
		@(posedge clk);
		if (o == OP_LOAD) loads_sent++;
		// random gaps: mostly none, sometimes short, rarely long
		gap = $urandom_range(0, 99);
		if (gap >= 60) begin
			@(negedge clk);
			start = 1'b0;
			repeat (gap >= 95 ? $urandom_range(10, 40) : $urandom_range(0, 3)) @(negedge clk);
		end
	endtask

	function automatic logic [23:0] rand_coord();
		logic [23:0] c;
		c = 24'($urandom);
		case ($urandom_range(0, 5))
			0: c[15:0] = 16'h0000;
			1: c[15:0] = 16'hFFFF;
			2: c[23:16] = 8'hFF;
			default: ;
		endcase
		return c;
	endfunction

	initial begin
		logic [7:0] shuffled [TABLE_SIZE];
		logic [7:0] tmp;
		int         j;
		logic [23:0] corners [6];
		idle_cycles = 0;
		loads_sent  = 0;
		start = 1'b0; op = OP_LOAD; perm_index = '0; perm_value = '0;
		coord_x = '0; coord_y = '0; coord_z = '0;
		arst_n = 1'b0;
		repeat (11) @(negedge clk);
		arst_n = 1'b1;

		// fill the whole table with a shuffled permutation before any sample
		for (int i = 0; i < TABLE_SIZE; i++) shuffled[i] = 8'(i);
		for (int i = TABLE_SIZE - 1; i > 0; i--) begin
			j = $urandom_range(0, i);
			tmp = shuffled[i]; shuffled[i] = shuffled[j]; shuffled[j] = tmp;
		end
		for (int i = 0; i < TABLE_SIZE; i++)
			send_request(OP_LOAD, 8'(i), shuffled[i], 24'($urandom), 24'($urandom),
				24'($urandom));

		// directed points: zero, max, cell edges and wrapping integer parts
		corners = '{24'h000000, 24'hFFFFFF, 24'hFF0000, 24'h00FFFF, 24'h008000, 24'h000001};
		for (int i = 0; i < 6; i++)
			send_request(OP_EVAL, '1, '1, corners[i], corners[i], corners[i]);
		for (int i = 0; i < 12; i++)
			send_request(OP_EVAL, '0, '0, corners[i % 6], corners[(i + 1) % 6],
				corners[(i + 3) % 6]);
		send_request(OP_LOAD, 8'hFF, 8'hFF, '1, '1, '1);
		send_request(OP_LOAD, 8'h00, 8'h00, '0, '0, '0);

		// random samples with occasional table rewrites
		for (int i = 0; i < 330; i++) begin
			if ($urandom_range(0, 19) == 0)
				send_request(OP_LOAD, 8'($urandom), 8'($urandom), 24'($urandom),
					24'($urandom), 24'($urandom));
			else
				send_request(OP_EVAL, 8'($urandom), 8'($urandom), rand_coord(),
					rand_coord(), rand_coord());
		end

		@(negedge clk);
		start = 1'b0;
		while (samples_pending != 0) @(negedge clk);
		repeat (20) @(negedge clk);

		$display("covered %0d table writes and %0d checked noise samples",
			loads_sent, samples_checked);
		if (errors == 0) begin
			$display("PASSED: all results match");
		end else begin
			$display("FAILED: results differ");
		end
		$finish;
	end

endmodule
